### sv/bmof_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmof_pkg
// types, constants and register map shared by the bitmap to font cell unit
// ----------------------------------------------------------------------------
package bmof_pkg;

    localparam logic [8:0]  MAX_ROW_BYTES    = 9'd256;
    localparam logic [10:0] MAX_ROWS         = 11'd1024;
    localparam logic [4:0]  LINES_PER_CELL   = 5'd18;

    localparam logic [8:0]  RST_ROW_BYTES    = 9'd4;
    localparam logic [10:0] RST_ROW_COUNT    = 11'd32;
    localparam logic [7:0]  RST_INDEX_BASE   = 8'd32;

    // ceil(2n/3) as ((2n+2) * 683) >> 11, exact for n up to 256
    localparam logic [10:0] DIV3_MUL         = 11'd683;
    localparam int          DIV3_SHIFT       = 11;

    localparam logic [1:0]  REG_ROW_BYTES    = 2'd0;
    localparam logic [1:0]  REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0]  REG_INDEX_BASE   = 2'd2;

    typedef struct packed {
        logic [8:0]  row_bytes;
        logic [10:0] row_count;
        logic [7:0]  index_base;
        logic [7:0]  cols;
        logic        restart;
    } t_cfg;

    typedef struct packed {
        logic [11:0] line_word;
        logic [5:0]  cell_row;
        logic [7:0]  cell_col;
        logic [4:0]  line_in_cell;
        logic [15:0] font_index;
        logic        last;
        logic        end_of_image;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage
`default_nettype wire

### sv/bmof_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmof_regs
// configuration registers behind the apb port, clamped values and column count
// ----------------------------------------------------------------------------
module bmof_regs
    import bmof_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [8:0]  r_row_bytes;
    logic [10:0] r_row_count;
    logic [7:0]  r_index_base;
    logic        r_restart;
    logic        wr_en;
    logic [8:0]  len;
    logic [9:0]  twice_len;
    logic [20:0] cols_prod;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes  <= RST_ROW_BYTES;
            r_row_count  <= RST_ROW_COUNT;
            r_index_base <= RST_INDEX_BASE;
            r_restart    <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (wr_en) begin
                unique case (paddr[3:2])
                    REG_ROW_BYTES: begin
                        r_row_bytes <= pwdata[8:0];
                        r_restart   <= 1'b1;
                    end
                    REG_ROW_COUNT: begin
                        r_row_count <= pwdata[10:0];
                        r_restart   <= 1'b1;
                    end
                    REG_INDEX_BASE: begin
                        r_index_base <= pwdata[7:0];
                        r_restart    <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROW_BYTES:  prdata = {23'd0, r_row_bytes};
            REG_ROW_COUNT:  prdata = {21'd0, r_row_count};
            REG_INDEX_BASE: prdata = {24'd0, r_index_base};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_row_bytes == 9'd0) begin
            len = 9'd1;
        end else if (r_row_bytes > MAX_ROW_BYTES) begin
            len = MAX_ROW_BYTES;
        end else begin
            len = r_row_bytes;
        end

        if (r_row_count == 11'd0) begin
            o_cfg.row_count = 11'd1;
        end else if (r_row_count > MAX_ROWS) begin
            o_cfg.row_count = MAX_ROWS;
        end else begin
            o_cfg.row_count = r_row_count;
        end

        twice_len        = {len, 1'b0} + 10'd2;
        cols_prod        = {11'd0, twice_len} * {10'd0, DIV3_MUL};
        o_cfg.row_bytes  = len;
        o_cfg.cols       = cols_prod[DIV3_SHIFT +: 8];
        o_cfg.index_base = r_index_base;
        o_cfg.restart    = r_restart;
    end

endmodule
`default_nettype wire

### sv/bmof_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmof_core
// position counters and byte repacking into tagged 12-bit font lines
// ----------------------------------------------------------------------------
module bmof_core
    import bmof_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_pixel_byte,
    output t_push           o_push
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } t_phase;

    t_phase      r_phase;
    logic [7:0]  r_byte_pos;
    logic [7:0]  r_col;
    logic [7:0]  r_held_first;
    logic [3:0]  r_held_second;
    logic [9:0]  r_row_number;
    logic [4:0]  r_line;
    logic [5:0]  r_cell_row;
    logic [15:0] r_row_index_base;

    logic        row_end;
    logic        img_end;
    logic [7:0]  col_odd;
    logic [4:0]  n_line;

    assign row_end = ({1'b0, r_byte_pos} + 9'd1) >= i_cfg.row_bytes;
    assign img_end = row_end && (({1'b0, r_row_number} + 11'd1) >= i_cfg.row_count);
    assign col_odd = r_col + 8'd1;
    assign n_line  = r_line + 5'd1;

    always_comb begin
        o_push                   = '0;
        o_push.res0.cell_row     = r_cell_row;
        o_push.res0.line_in_cell = r_line;
        o_push.res0.cell_col     = r_col;
        o_push.res1.cell_row     = r_cell_row;
        o_push.res1.line_in_cell = r_line;
        o_push.res1.cell_col     = col_odd;
        o_push.res1.line_word    = {i_pixel_byte[3:0], 8'h00};
        unique case (r_phase)
            PH_FIRST: begin
                o_push.count          = row_end ? 2'd1 : 2'd0;
                o_push.res0.line_word = {i_pixel_byte, 4'h0};
            end
            PH_SECOND: begin
                o_push.count          = row_end ? 2'd2 : 2'd1;
                o_push.res0.line_word = {r_held_first, i_pixel_byte[7:4]};
            end
            PH_THIRD: begin
                o_push.count          = 2'd1;
                o_push.res0.line_word = {r_held_second, i_pixel_byte};
                o_push.res0.cell_col  = col_odd;
            end
            default: begin
                o_push.count = 2'd0;
            end
        endcase
        o_push.res0.font_index = r_row_index_base + {8'h00, o_push.res0.cell_col};
        o_push.res1.font_index = r_row_index_base + {8'h00, o_push.res1.cell_col};
        if (o_push.count == 2'd2) begin
            o_push.res1.last         = 1'b1;
            o_push.res1.end_of_image = img_end;
        end else begin
            o_push.res0.last         = 1'b1;
            o_push.res0.end_of_image = img_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_FIRST;
            r_byte_pos       <= '0;
            r_col            <= '0;
            r_held_first     <= '0;
            r_held_second    <= '0;
            r_row_number     <= '0;
            r_line           <= '0;
            r_cell_row       <= '0;
            r_row_index_base <= {8'h00, RST_INDEX_BASE};
        end else if (i_cfg.restart || (i_accept && img_end)) begin
            r_phase          <= PH_FIRST;
            r_byte_pos       <= '0;
            r_col            <= '0;
            r_held_first     <= '0;
            r_held_second    <= '0;
            r_row_number     <= '0;
            r_line           <= '0;
            r_cell_row       <= '0;
            r_row_index_base <= {8'h00, i_cfg.index_base};
        end else if (i_accept) begin
            unique case (r_phase)
                PH_FIRST: begin
                    r_held_first <= i_pixel_byte;
                    r_phase      <= PH_SECOND;
                end
                PH_SECOND: begin
                    r_held_second <= i_pixel_byte[3:0];
                    r_phase       <= PH_THIRD;
                end
                PH_THIRD: begin
                    r_phase <= PH_FIRST;
                end
                default: begin
                    r_phase <= PH_FIRST;
                end
            endcase
            if (row_end) begin
                r_phase      <= PH_FIRST;
                r_byte_pos   <= '0;
                r_col        <= '0;
                r_row_number <= r_row_number + 10'd1;
                if (n_line >= LINES_PER_CELL) begin
                    r_line           <= '0;
                    r_cell_row       <= r_cell_row + 6'd1;
                    r_row_index_base <= r_row_index_base + {8'h00, i_cfg.cols};
                end else begin
                    r_line <= n_line;
                end
            end else begin
                r_byte_pos <= r_byte_pos + 8'd1;
                if (r_phase == PH_THIRD) begin
                    r_col <= r_col + 8'd2;
                end
            end
        end
    end

endmodule
`default_nettype wire

### sv/bmof_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmof_queue
// four-entry result queue, up to two words in and one word out per cycle
// ----------------------------------------------------------------------------
module bmof_queue
    import bmof_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_en,
    input  t_push     i_push,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_room,
    output t_result   o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [1:0] push_n;
    logic       pop_en;

    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign o_valid = r_count != 3'd0;
    assign o_room  = r_count <= 3'd2;
    assign pop_en  = i_pop && o_valid;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop_en};
            r_count  <= r_count + {1'b0, push_n} - {2'b00, pop_en};
        end
    end

endmodule
`default_nettype wire

### sv/bitmap_to_osd_font_cells_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_to_osd_font_cells_unit
// repacks a one-bit-per-pixel bitmap into tagged 12-bit osd font lines
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_pixel_byte
// out       output     o_out_valid / i_out_ready   o_line_word .. o_end_of_image
// cfg       input      psel penable pwrite pready  paddr pwdata prdata
//
// one byte per cycle is taken while o_in_ready is high; its lines reach the
// result queue at the same edge. a byte that ends a row on the second byte of
// a group gives two words, which leave the four-entry queue one at a time;
// o_in_ready drops while three or more words wait and while the restart strobe
// of a mapped register write is high. reset is synchronous, with no clearing pass
// ----------------------------------------------------------------------------
module bitmap_to_osd_font_cells_unit
    import bmof_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_pixel_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [11:0] o_line_word,
    output logic      [5:0]  o_cell_row,
    output logic      [7:0]  o_cell_col,
    output logic      [4:0]  o_line_in_cell,
    output logic      [15:0] o_font_index,
    output logic             o_last,
    output logic             o_end_of_image
);

    t_cfg    cfg;
    t_push   push;
    t_result head;
    logic    room;
    logic    accept;

    assign o_in_ready = room && !cfg.restart;
    assign accept     = i_in_valid && o_in_ready;

    bmof_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bmof_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_pixel_byte (i_pixel_byte),
        .o_push       (push)
    );

    bmof_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .i_pop     (i_out_ready),
        .o_valid   (o_out_valid),
        .o_room    (room),
        .o_head    (head)
    );

    assign o_line_word    = head.line_word;
    assign o_cell_row     = head.cell_row;
    assign o_cell_col     = head.cell_col;
    assign o_line_in_cell = head.line_in_cell;
    assign o_font_index   = head.font_index;
    assign o_last         = head.last;
    assign o_end_of_image = head.end_of_image;

endmodule
`default_nettype wire

### sv/bmof_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmof_checker
// port-level assertions for the bitmap to font cell unit
// ----------------------------------------------------------------------------
module bmof_checker
    import bmof_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [11:0] o_line_word,
    input wire logic [5:0]  o_cell_row,
    input wire logic [7:0]  o_cell_col,
    input wire logic [4:0]  o_line_in_cell,
    input wire logic [15:0] o_font_index,
    input wire logic        o_last,
    input wire logic        o_end_of_image
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_word)
            && $stable(o_cell_row) && $stable(o_cell_col) && $stable(o_line_in_cell)
            && $stable(o_font_index) && $stable(o_last) && $stable(o_end_of_image))
        else $error("stalled output word changed");

    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_image |-> o_last)
        else $error("end of image without last");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_in_cell < LINES_PER_CELL)
        else $error("line in cell out of range");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite
            && (paddr[3:2] == REG_ROW_BYTES || paddr[3:2] == REG_ROW_COUNT
                || paddr[3:2] == REG_INDEX_BASE) |=> !o_in_ready)
        else $error("byte taken during image restart");

endmodule

bind bitmap_to_osd_font_cells_unit bmof_checker u_bmof_checker (.*);
`default_nettype wire

### test/bitmap_to_osd_font_cells_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_to_osd_font_cells_unit_test
// Self-checking bench for the bitmap to osd font cell repacker. Bitmap bytes
// go in over a valid/ready channel, and an in-bench model of the repacking
// predicts every tagged font line word. Words are checked in order as they
// leave the block. Both sides idle in random bursts.
// Test tasks: register access, directed group and row endings, a write to an
// unmapped register, a tall image that reaches the row clamp, a wide image
// that reaches the byte clamp, random images with restarts part-way through,
// and a final stretch with no idling.
// ----------------------------------------------------------------------------
module bitmap_to_osd_font_cells_unit_test;
    import bmof_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {GROUP_FIRST, GROUP_SECOND, GROUP_THIRD} t_group_phase;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = 4'h0;
    logic [31:0] pwdata       = 32'h0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_pixel_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [11:0] o_line_word;
    logic [5:0]  o_cell_row;
    logic [7:0]  o_cell_col;
    logic [4:0]  o_line_in_cell;
    logic [15:0] o_font_index;
    logic        o_last;
    logic        o_end_of_image;

    bitmap_to_osd_font_cells_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_byte   (i_pixel_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_line_word    (o_line_word),
        .o_cell_row     (o_cell_row),
        .o_cell_col     (o_cell_col),
        .o_line_in_cell (o_line_in_cell),
        .o_font_index   (o_font_index),
        .o_last         (o_last),
        .o_end_of_image (o_end_of_image)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state
    logic [8:0]   cfg_row_bytes;
    logic [10:0]  cfg_row_count;
    logic [7:0]   cfg_index_base;
    logic [7:0]   byte_pos;
    t_group_phase grp_phase;
    logic [7:0]   held_a;
    logic [7:0]   held_b;
    logic [9:0]   row_num;
    logic [4:0]   line_cnt;
    logic [5:0]   cell_row_cnt;
    logic [15:0]  row_font_base;

    t_result pending_lines [$];

    int errors       = 0;
    int bytes_sent   = 0;
    int lines_seen   = 0;
    int images_done  = 0;
    int reg_writes   = 0;
    int settings_cnt = 0;
    int cycles       = 0;
    int in_idle_pct  = 25;
    int out_idle_pct = 25;
    int stall_left   = 0;
    bit quiet        = 1'b0;

    t_result got_line;
    t_result want_line;

    function automatic void restart_image();
        byte_pos      = 8'd0;
        grp_phase     = GROUP_FIRST;
        held_a        = 8'd0;
        held_b        = 8'd0;
        row_num       = 10'd0;
        line_cnt      = 5'd0;
        cell_row_cnt  = 6'd0;
        row_font_base = {8'd0, cfg_index_base};
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_ROW_BYTES: begin
                cfg_row_bytes = val[8:0];
                restart_image();
            end
            REG_ROW_COUNT: begin
                cfg_row_count = val[10:0];
                restart_image();
            end
            REG_INDEX_BASE: begin
                cfg_index_base = val[7:0];
                restart_image();
            end
            default: ;
        endcase
    endfunction

    function automatic t_result font_line(logic [11:0] word, int col);
        t_result r;
        r.line_word    = word;
        r.cell_row     = cell_row_cnt;
        r.cell_col     = col[7:0];
        r.line_in_cell = line_cnt;
        r.font_index   = row_font_base + 16'(col);
        r.last         = 1'b0;
        r.end_of_image = 1'b0;
        return r;
    endfunction

    function automatic void predict_font_lines(logic [7:0] b);
        t_result lines [2];
        int      n;
        int      len;
        int      rows;
        int      cols;
        int      col;
        bit      row_end;
        bit      img_end;
        n    = 0;
        len  = (cfg_row_bytes == 9'd0) ? 1 :
               (cfg_row_bytes > MAX_ROW_BYTES) ? int'(MAX_ROW_BYTES) : int'(cfg_row_bytes);
        rows = (cfg_row_count == 11'd0) ? 1 :
               (cfg_row_count > MAX_ROWS) ? int'(MAX_ROWS) : int'(cfg_row_count);
        cols    = (8 * len + 11) / 12;
        row_end = (int'(byte_pos) + 1 >= len);
        img_end = row_end && (int'(row_num) + 1 >= rows);
        col     = (int'(byte_pos) / 3) * 2;
        case (grp_phase)
            GROUP_FIRST: begin
                held_a = b;
                if (row_end) begin
                    lines[n] = font_line({b, 4'h0}, col);
                    n++;
                end
                grp_phase = GROUP_SECOND;
            end
            GROUP_SECOND: begin
                held_b = b;
                lines[n] = font_line({held_a, b[7:4]}, col);
                n++;
                if (row_end) begin
                    lines[n] = font_line({b[3:0], 8'h00}, col + 1);
                    n++;
                end
                grp_phase = GROUP_THIRD;
            end
            default: begin
                lines[n] = font_line({held_b[3:0], b}, col + 1);
                n++;
                grp_phase = GROUP_FIRST;
            end
        endcase
        if (n > 0) begin
            lines[n-1].last         = 1'b1;
            lines[n-1].end_of_image = img_end;
        end
        for (int k = 0; k < n; k++) pending_lines.push_back(lines[k]);
        if (img_end) begin
            restart_image();
        end else if (row_end) begin
            byte_pos  = 8'd0;
            grp_phase = GROUP_FIRST;
            row_num   = row_num + 10'd1;
            line_cnt  = line_cnt + 5'd1;
            if (line_cnt >= LINES_PER_CELL) begin
                line_cnt      = 5'd0;
                cell_row_cnt  = cell_row_cnt + 6'd1;
                row_font_base = row_font_base + 16'(cols);
            end
        end else begin
            byte_pos = byte_pos + 8'd1;
        end
    endfunction

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_lines.size());
            $display("bitmap_to_osd_font_cells_unit_test NOT OK");
            $finish;
        end
    end

    // output stall bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left  <= 0;
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            stall_left  <= $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_line.line_word    = o_line_word;
            got_line.cell_row     = o_cell_row;
            got_line.cell_col     = o_cell_col;
            got_line.line_in_cell = o_line_in_cell;
            got_line.font_index   = o_font_index;
            got_line.last         = o_last;
            got_line.end_of_image = o_end_of_image;
            lines_seen++;
            if (o_end_of_image) images_done++;
            if (pending_lines.size() == 0) begin
                note_mismatch($sformatf("word %h with nothing expected", o_line_word));
            end else begin
                want_line = pending_lines.pop_front();
                if (got_line !== want_line)
                    note_mismatch($sformatf({"word %h/%h row %0d/%0d col %0d/%0d ",
                        "line %0d/%0d index %0d/%0d last %0d/%0d eoi %0d/%0d (exp/got)"},
                        want_line.line_word, got_line.line_word,
                        want_line.cell_row, got_line.cell_row,
                        want_line.cell_col, got_line.cell_col,
                        want_line.line_in_cell, got_line.line_in_cell,
                        want_line.font_index, got_line.font_index,
                        want_line.last, got_line.last,
                        want_line.end_of_image, got_line.end_of_image));
            end
        end
    end

    task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr) begin
            apply_register(idx, wdata);
            reg_writes++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        reg_access(1'b0, idx, 32'h0, got);
        if (got !== want)
            note_mismatch($sformatf("register %0d read %h, expected %h", idx, got, want));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int rb, input int rc, input int ib);
        logic [31:0] v;
        logic [31:0] unused;
        drain();
        v = $urandom;
        v[8:0] = 9'(rb);
        reg_access(1'b1, REG_ROW_BYTES, v, unused);
        v = $urandom;
        v[10:0] = 11'(rc);
        reg_access(1'b1, REG_ROW_COUNT, v, unused);
        v = $urandom;
        v[7:0] = 8'(ib);
        reg_access(1'b1, REG_INDEX_BASE, v, unused);
        settings_cnt++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < in_idle_pct) gap = $urandom_range(1, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_font_lines(b);
        bytes_sent++;
    endtask

    task automatic test_register_access();
        logic [31:0] v;
        logic [31:0] mask;
        logic [31:0] unused;
        logic [1:0]  idx;
        check_reg(REG_ROW_BYTES, 32'(RST_ROW_BYTES));
        check_reg(REG_ROW_COUNT, 32'(RST_ROW_COUNT));
        check_reg(REG_INDEX_BASE, 32'(RST_INDEX_BASE));
        for (int k = 0; k < 3; k++) begin
            idx = 2'(k);
            case (idx)
                REG_ROW_BYTES: mask = 32'h1ff;
                REG_ROW_COUNT: mask = 32'h7ff;
                default:       mask = 32'hff;
            endcase
            v = $urandom;
            reg_access(1'b1, idx, v, unused);
            check_reg(idx, v & mask);
        end
    endtask

    task automatic test_directed_groups();
        // reset geometry: a four byte row ends on the first byte of a group
        set_config(RST_ROW_BYTES, RST_ROW_COUNT, RST_INDEX_BASE);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h01);
        // row ends on the second byte, single row image, top index
        set_config(2, 1, 255);
        send_byte(8'ha5);
        send_byte(8'h5a);
        send_byte(8'hff);
        send_byte(8'h0f);
        // full group per row
        set_config(3, 1, 0);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        // zero sizes act as one
        set_config(0, 0, 128);
        send_byte(8'hc3);
        send_byte(8'h3c);
    endtask

    task automatic test_unmapped_register();
        logic [31:0] unused;
        set_config(5, 2, 7);
        send_byte(8'h96);
        send_byte(8'h69);
        drain();
        // must not restart the image
        reg_access(1'b1, REG_UNMAPPED, $urandom, unused);
        repeat (8) send_byte(8'($urandom));
    endtask

    task automatic test_tall_image();
        in_idle_pct  = 10;
        out_idle_pct = 10;
        // row count above the maximum acts as the maximum
        set_config(1, 2047, 200);
        repeat (1030) send_byte(8'($urandom));
    endtask

    task automatic test_wide_rows();
        in_idle_pct  = 20;
        out_idle_pct = 20;
        set_config(511, 1, 0);
        repeat (260) send_byte(8'($urandom));
    endtask

    task automatic test_random_images();
        int sent;
        int n;
        int rb;
        int rc;
        sent = 0;
        while (sent < 130) begin
            rb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            rc = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
            in_idle_pct  = 20 * $urandom_range(0, 3);
            out_idle_pct = 20 * $urandom_range(0, 3);
            set_config(rb, rc, $urandom_range(0, 255));
            n = $urandom_range(20, 80);
            repeat (n) send_byte(8'($urandom));
            sent += n;
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        set_config(7, 3, 99);
        repeat (100) send_byte(8'($urandom));
    endtask

    initial begin
        cfg_row_bytes  = RST_ROW_BYTES;
        cfg_row_count  = RST_ROW_COUNT;
        cfg_index_base = RST_INDEX_BASE;
        restart_image();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_access();
        test_directed_groups();
        test_unmapped_register();
        test_tall_image();
        test_wide_rows();
        test_random_images();
        test_back_to_back();
        i_in_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d bitmap bytes, checked %0d font line words, %0d images completed",
                 bytes_sent, lines_seen, images_done);
        $display("%0d register writes over %0d geometry settings, %0d mismatches",
                 reg_writes, settings_cnt, errors);
        if (errors == 0 && pending_lines.size() == 0) begin
            $display("bitmap_to_osd_font_cells_unit_test OK");
        end else begin
            $display("bitmap_to_osd_font_cells_unit_test NOT OK");
        end
        $finish;
    end

endmodule
